@@ hw/rtl/bob_pkg.sv @@
// ----------------------------------------------------------------------------
// bob_pkg
// Shared types and constants for the block Otsu binarizer.
// ----------------------------------------------------------------------------
package bob_pkg;
  localparam int BLOCK_W_DEF = 32;
  localparam int BLOCK_H_DEF = 32;
  localparam int LEVELS      = 256;
  localparam int CNT_W       = 11;
  localparam int ADDR_ROWS   = 0;
  localparam int ADDR_COLS   = 1;

  typedef struct packed {
    logic [5:0] rows;
    logic [5:0] cols;
  } dims_t;
endpackage

@@ hw/rtl/bob_front.sv @@
// ----------------------------------------------------------------------------
// bob_front
// Pixel intake: stores pixels, builds the histogram, hands off finished blocks.
// ----------------------------------------------------------------------------
module bob_front import bob_pkg::*; #(
  parameter int BLOCK_W = BLOCK_W_DEF,
  parameter int BLOCK_H = BLOCK_H_DEF,
  localparam int DEPTH  = BLOCK_W * BLOCK_H,
  localparam int AW     = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  dims_t            dims,
  input  logic             clear,
  input  logic             push,
  output logic             full,
  input  logic [7:0]       pixel,
  output logic             blk_valid,
  input  logic             blk_done,
  input  logic [7:0]       hist_addr,
  output logic [CNT_W-1:0] hist_data,
  input  logic [AW-1:0]    pix_addr,
  output logic [7:0]       pix_data
);
  logic [CNT_W-1:0] hist [LEVELS];
  logic [LEVELS-1:0] hvalid;
  logic [7:0] store [DEPTH];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] total;
  logic [1:0] state;
  logic [7:0] upd_bin;
  logic [CNT_W-1:0] upd_val;
  logic upd;
  localparam logic [1:0] S_TAKE = 2'd0, S_BUMP = 2'd1, S_HOLD = 2'd2;

  assign total = CNT_W'(dims.rows * dims.cols);
  assign full = (state != S_TAKE);
  assign blk_valid = (state == S_HOLD);

  always_ff @(posedge clk) begin
    // count stays below the block size while intake is open
    if (push && !full) store[AW'(count)] <= pixel;
    pix_data <= store[pix_addr];
    hist_data <= hvalid[hist_addr] ? hist[hist_addr] : '0;
    upd_val <= hvalid[pixel] ? hist[pixel] : '0;
    if (push && !full) upd_bin <= pixel;
    if (upd) hist[upd_bin] <= upd_val + 1'b1;
  end

  assign upd = (state == S_BUMP);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      state <= S_TAKE;
      count <= '0;
      hvalid <= '0;
    end else begin
      unique case (state)
        S_TAKE: if (push) begin
          count <= count + 1'b1;
          state <= S_BUMP;
        end
        S_BUMP: begin
          hvalid[upd_bin] <= 1'b1;
          state <= (count >= total) ? S_HOLD : S_TAKE;
        end
        S_HOLD: if (blk_done) begin
          state <= S_TAKE;
          count <= '0;
          hvalid <= '0;
        end
        default: state <= S_TAKE;
      endcase
    end
  end
endmodule

@@ hw/rtl/bob_back.sv @@
// ----------------------------------------------------------------------------
// bob_back
// Level search over the histogram and row packing into a small result queue.
// ----------------------------------------------------------------------------
module bob_back import bob_pkg::*; #(
  parameter int BLOCK_W = BLOCK_W_DEF,
  parameter int BLOCK_H = BLOCK_H_DEF,
  localparam int DEPTH  = BLOCK_W * BLOCK_H,
  localparam int AW     = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  dims_t            dims,
  input  logic             clear,
  input  logic             blk_valid,
  output logic             blk_done,
  output logic [7:0]       hist_addr,
  input  logic [CNT_W-1:0] hist_data,
  output logic [AW-1:0]    pix_addr,
  input  logic [7:0]       pix_data,
  output logic             empty,
  input  logic             pop,
  output logic [31:0]      row_bits,
  output logic [4:0]       row_index,
  output logic [7:0]       level,
  output logic             last_row
);
  localparam logic [3:0] S_IDLE = 4'd0, S_SUM = 4'd1, S_SCAN = 4'd2, S_M1 = 4'd3,
    S_M2 = 4'd4, S_M3 = 4'd5, S_CMP = 4'd6, S_ROW = 4'd7, S_PUSH = 4'd8,
    S_DONE = 4'd9, S_SQ = 4'd10, S_PL = 4'd11, S_PH = 4'd12;
  logic [3:0] state;
  logic [8:0] t;
  logic [CNT_W-1:0] n, w0, w1;
  logic [18:0] total, s0;
  logic [29:0] a, b, d;
  logic [59:0] num, bnum;
  logic [21:0] den, bden;
  logic [81:0] lhs, rhs;
  logic [7:0] best;
  logic [4:0] r;
  logic [5:0] c;
  logic [AW-1:0] base;
  logic [31:0] bits;
  logic qv;

  assign hist_addr = t[7:0];
  assign pix_addr  = base + AW'(c);
  assign n = CNT_W'(dims.rows * dims.cols);
  assign empty = !qv;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      state <= S_IDLE;
      qv <= 1'b0;
      blk_done <= 1'b0;
    end else begin
      blk_done <= 1'b0;
      if (pop && qv) qv <= 1'b0;
      unique case (state)
        S_IDLE: if (blk_valid && !blk_done) begin
          t <= '0; total <= '0; state <= S_SUM;
        end
        S_SUM: begin
          // registered read: bin t-1 arrives while t is addressed
          if (t != 0) total <= total + 19'(hist_data * (t - 9'd1));
          if (t == 9'd256) begin
            t <= '0; w0 <= '0; s0 <= '0; bnum <= '0; bden <= 22'd1; best <= '0;
            state <= S_SCAN;
          end else t <= t + 1'b1;
        end
        S_SCAN: begin
          // bin t is read here and arrives in S_M1
          state <= S_M1;
        end
        S_M1: begin
          w0 <= w0 + hist_data;
          s0 <= s0 + 19'(hist_data * t[7:0]);
          w1 <= n - (w0 + hist_data);
          state <= S_M2;
        end
        S_M2: begin
          a <= 30'(s0 * n);
          b <= 30'(total * w0);
          state <= S_M3;
        end
        S_M3: begin
          d <= (a > b) ? a - b : b - a;
          den <= 22'(w0 * w1);
          state <= S_SQ;
        end
        S_SQ: begin
          num <= 60'(d * d);
          state <= S_PL;
        end
        S_PL: begin
          lhs <= 82'(num[29:0] * bden);
          rhs <= 82'(bnum[29:0] * den);
          state <= S_PH;
        end
        S_PH: begin
          lhs <= lhs + (82'(num[59:30] * bden) << 30);
          rhs <= rhs + (82'(bnum[59:30] * den) << 30);
          state <= S_CMP;
        end
        S_CMP: begin
          if (w0 != 0 && w1 != 0 && lhs > rhs) begin
            bnum <= num; bden <= den; best <= t[7:0];
          end
          if (t == 9'd255) begin
            r <= '0; c <= '0; base <= '0; bits <= '0; state <= S_ROW;
          end else begin
            t <= t + 1'b1; state <= S_SCAN;
          end
        end
        S_ROW: begin
          // pixel for column c-1 arrives now
          if (c != 0 && 11'(5 * pix_data) > 11'(4 * best))
            bits[5'd31 - 5'(c - 6'd1)] <= 1'b1;
          if (c == dims.cols) state <= S_PUSH;
          else c <= c + 1'b1;
        end
        S_PUSH: if (!qv || pop) begin
          qv <= 1'b1;
          row_bits <= bits; row_index <= r; level <= best;
          last_row <= (6'(r) + 6'd1 == dims.rows);
          if (6'(r) + 6'd1 == dims.rows) state <= S_DONE;
          else begin
            r <= r + 1'b1; c <= '0; bits <= '0;
            base <= base + AW'(dims.cols); state <= S_ROW;
          end
        end
        S_DONE: begin
          blk_done <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ hw/rtl/block_otsu_binarize.sv @@
// ----------------------------------------------------------------------------
// block_otsu_binarize
// Otsu thresholding of a gray block, one packed row of bits per block row.
// ----------------------------------------------------------------------------
// Intake: full rises for the histogram read-modify-write after each pixel, so pixels are not taken back to back.
// Per block: a histogram sum pass, a level search through S_SCAN..S_CMP for each level, then a column pass per row.
// Result queue is one entry; rows wait while it is occupied.
// Reset (rst, synchronous): rows min(BLOCK_H,32), cols min(BLOCK_W,32), histogram and count cleared.
module block_otsu_binarize import bob_pkg::*; #(
  parameter int BLOCK_W = BLOCK_W_DEF,
  parameter int BLOCK_H = BLOCK_H_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  pixel,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] row_bits,
  output logic [4:0]  row_index,
  output logic [7:0]  level,
  output logic        last_row
);
  localparam int RCAP = BLOCK_H < 32 ? BLOCK_H : 32;
  localparam int CCAP = BLOCK_W < 32 ? BLOCK_W : 32;
  localparam int AW = $clog2(BLOCK_W * BLOCK_H);
  dims_t dims;
  logic wr, clear, blk_valid, blk_done;
  logic [7:0] hist_addr, pix_data;
  logic [CNT_W-1:0] hist_data;
  logic [AW-1:0] pix_addr;
  logic [5:0] v;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign v = pwdata[5:0];
  // any register write drops a partial block
  assign clear = wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      dims.rows <= 6'(RCAP);
      dims.cols <= 6'(CCAP);
    end else if (clear) begin
      if (paddr[2:2] == 1'(ADDR_ROWS))
        dims.rows <= (v == 0) ? 6'd1 : (v > 6'(RCAP)) ? 6'(RCAP) : v;
      else
        dims.cols <= (v == 0) ? 6'd1 : (v > 6'(CCAP)) ? 6'(CCAP) : v;
    end
  end

  always_comb begin
    if (paddr[2:2] == 1'(ADDR_ROWS)) prdata = 32'(dims.rows);
    else prdata = 32'(dims.cols);
  end

  bob_front #(.BLOCK_W(BLOCK_W), .BLOCK_H(BLOCK_H)) u_front (
    .clk, .rst, .dims, .clear, .push, .full, .pixel, .blk_valid, .blk_done,
    .hist_addr, .hist_data, .pix_addr, .pix_data);

  bob_back #(.BLOCK_W(BLOCK_W), .BLOCK_H(BLOCK_H)) u_back (
    .clk, .rst, .dims, .clear, .blk_valid, .blk_done, .hist_addr, .hist_data,
    .pix_addr, .pix_data, .empty, .pop, .row_bits, .row_index, .level,
    .last_row);

  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    blk_valid |-> full) else $error("intake open while block pending");
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    (!empty && last_row) |-> (6'(row_index) + 6'd1 == dims.rows || $past(clear)))
    else $error("last row index mismatch");
endmodule
